// ----- hw/rtl/cnv3_pkg.sv -----
// shared types and constants of the 3x3 zero padded convolution filter
// no dependencies; imported by the top level, front end and back end
package cnv3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 10;
    localparam int VALUE_W    = 28;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_CFG_W  = 11;
    localparam int COEF_SLOT  = 16;
    localparam int NB_SIZE    = 9;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COEF_BITS  = 16;

    localparam int QUEUE_DEPTH = 8;
    localparam int OUT_DEPTH   = 8;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
    localparam int OCW         = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_DATA_W-1:0] KERNEL_OUTER_RST  = 48'd68721573904;
    localparam logic [CFG_DATA_W-1:0] KERNEL_MIDDLE_RST = 48'd137443147808;
    localparam logic [DIM_CFG_W-1:0]  DIM_RST           = 11'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MIDDLE = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_IMAGE_WIDTH   = 3'd3,
        REG_IMAGE_HEIGHT  = 3'd4
    } t_cfg_reg;

    // neighbourhood beat from front to back, padded pixels already zeroed
    typedef struct packed {
        logic [NB_SIZE-1:0][PIX_W-1:0] pix;
        logic [ROW_W-1:0]              row;
        logic [ROW_W-1:0]              col;
        logic                          last;
    } t_win_pkt;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [ROW_W-1:0]          row;
        logic [ROW_W-1:0]          col;
        logic                      last;
    } t_result;

endpackage

// ----- hw/rtl/conv3x3_zero_pad_filter.sv -----
// top level of the 3x3 zero padded convolution filter: config registers,
// front end, middle queue, back end and result fifo; depends on cnv3_pkg
// and all cnv3_* modules
//
// The filter takes one pixel beat per clock and returns each result beat
// through the front end registers, middle queue, product and row-sum registers
// and result fifo; a new pixel is taken every cycle as long as the result fifo
// keeps draining, the line buffer memory doing one read and one write per
// pixel. After reset the line buffer is cleared one entry per cycle, and full
// stays high until the clear is done; configuration writes are taken during it.
// Each frame is followed by width+1 flush beats that push the last rows out.
module conv3x3_zero_pad_filter
    import cnv3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = DEF_COEF_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [PIX_W-1:0]          i_pixel,
    input  logic                      i_flush,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] o_filtered_value,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [ROW_W-1:0]          o_out_col,
    output logic                      o_frame_last,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [2:0][CFG_DATA_W-1:0] r_kernel;
    logic [DIM_CFG_W-1:0]       r_width;
    logic [DIM_CFG_W-1:0]       r_height;
    logic [DW-1:0]              width;
    logic [HW-1:0]              height;

    logic           q_push, q_pop, q_empty;
    t_win_pkt       q_in, q_out;
    logic [QCW-1:0] q_count;
    logic           res_push;
    t_result        res_in, res_out;
    logic [OCW-1:0] out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel[0] <= KERNEL_OUTER_RST;
            r_kernel[1] <= KERNEL_MIDDLE_RST;
            r_kernel[2] <= KERNEL_OUTER_RST;
            r_width     <= DIM_RST;
            r_height    <= DIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KERNEL_TOP:    r_kernel[0] <= i_cfg_data;
                REG_KERNEL_MIDDLE: r_kernel[1] <= i_cfg_data;
                REG_KERNEL_BOTTOM: r_kernel[2] <= i_cfg_data;
                REG_IMAGE_WIDTH:   r_width     <= i_cfg_data[DIM_CFG_W-1:0];
                REG_IMAGE_HEIGHT:  r_height    <= i_cfg_data[DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize counts as the maximum
    always_comb begin
        if (r_width == '0) begin
            width = DW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            width = DW'(MAX_WIDTH);
        end else begin
            width = DW'(r_width);
        end
        if (r_height == '0) begin
            height = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            height = HW'(MAX_HEIGHT);
        end else begin
            height = HW'(r_height);
        end
    end

    cnv3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pixel   (i_pixel),
        .i_flush   (i_flush),
        .i_width   (width),
        .i_height  (height),
        .i_q_count (q_count),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_pkt   (q_in)
    );

    cnv3_fifo #(
        .WIDTH ($bits(t_win_pkt)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    cnv3_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kernel    (r_kernel),
        .i_q_empty   (q_empty),
        .i_q_pkt     (q_out),
        .i_out_count (out_count),
        .o_q_pop     (q_pop),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    cnv3_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_filtered_value = res_out.value;
    assign o_out_row        = res_out.row;
    assign o_out_col        = res_out.col;
    assign o_frame_last     = res_out.last;

`ifndef ASSERT_OFF
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QCW'(QUEUE_DEPTH)))
        else $error("middle queue written while full");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (out_count < OCW'(OUT_DEPTH)))
        else $error("result fifo written while full");

    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("input open during line buffer clear");
`endif

endmodule

// ----- hw/rtl/cnv3_fifo.sv -----
// small register fifo used between front and back and on the result side
// depends on nothing; writer must respect the occupancy count
module cnv3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd, n_rd;
    logic [PW-1:0]    r_wr, n_wr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/cnv3_front.sv -----
// front end: position counters, line buffer memory, 3x3 window and padding
// depends on cnv3_pkg; feeds neighbourhood beats into the middle queue
module cnv3_front
    import cnv3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT + 3)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_flush,
    input  logic [DW-1:0]    i_width,
    input  logic [HW-1:0]    i_height,
    input  logic [QCW-1:0]   i_q_count,
    output logic             o_full,
    output logic             o_q_push,
    output t_win_pkt         o_q_pkt
);

    // line buffer entry: row two up in the high byte, row one up in the low byte
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_q;
    logic               r_fwd_v;
    logic [2*PIX_W-1:0] r_fwd_d;

    logic          r_busy;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_ic, n_ic;
    logic [RW-1:0] r_ir, n_ir;

    logic               r_s1_v;
    logic               r_s1_out;
    logic               r_s1_col0;
    logic [AW-1:0]      r_s1_ic;
    logic [PIX_W-1:0]   r_s1_p;
    logic [NB_SIZE-1:0] r_s1_keep;
    logic [ROW_W-1:0]   r_s1_row;
    logic [ROW_W-1:0]   r_s1_col;
    logic               r_s1_last;

    logic [NB_SIZE-1:0][PIX_W-1:0] r_win, n_win;
    logic [NB_SIZE-1:0][PIX_W-1:0] nb;

    logic               acc;
    logic               restart;
    logic [AW-1:0]      ic;
    logic [RW-1:0]      ir;
    logic [RW-1:0]      cr;
    logic [AW-1:0]      cc;
    logic               valid;
    logic               last;
    logic [DW-1:0]      ic1;
    logic [NB_SIZE-1:0] keep;
    logic [PIX_W-1:0]   p;
    logic [2*PIX_W-1:0] q;
    logic               wr_en;
    logic [AW-1:0]      wr_a;
    logic [2*PIX_W-1:0] wr_d;

    assign o_full = r_busy
        || ((QCW + 1)'(i_q_count) + (QCW + 1)'(r_s1_v) >= (QCW + 1)'(QUEUE_DEPTH));
    assign acc = i_push && !o_full;
    assign p   = i_flush ? '0 : i_pixel;

    // classify the incoming beat
    always_comb begin
        restart = (DW'(r_ic) >= i_width) || (r_ir > RW'(i_height) + RW'(1));
        ic      = restart ? '0 : r_ic;
        ir      = restart ? '0 : r_ir;
        if (ic == '0) begin
            valid = (ir >= RW'(2));
            cr    = ir - RW'(2);
            cc    = AW'(i_width - DW'(1));
        end else begin
            valid = (ir >= RW'(1));
            cr    = ir - RW'(1);
            cc    = ic - AW'(1);
        end
        valid = valid && (cr < RW'(i_height));
        last  = valid && (cr == RW'(i_height) - RW'(1)) && (DW'(cc) == i_width - DW'(1));
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                keep[r*3+c] = !((r == 0) && (cr == '0))
                    && !((r == 2) && (cr == RW'(i_height) - RW'(1)))
                    && !((c == 0) && (cc == '0))
                    && !((c == 2) && (DW'(cc) == i_width - DW'(1)));
            end
        end
        ic1  = DW'(ic) + DW'(1);
        n_ic = AW'(ic1);
        n_ir = ir;
        if (last) begin
            n_ic = '0;
            n_ir = '0;
        end else if (ic1 >= i_width) begin
            n_ic = '0;
            n_ir = ir + RW'(1);
        end
    end

    // window shift and neighbourhood selection
    always_comb begin
        q = r_fwd_v ? r_fwd_d : r_q;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3+0] = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = q[2*PIX_W-1:PIX_W];
        n_win[5] = q[PIX_W-1:0];
        n_win[8] = r_s1_p;
        if (r_s1_col0) begin
            for (int r = 0; r < 3; r++) begin
                nb[r*3+0] = r_win[r*3+1];
                nb[r*3+1] = r_win[r*3+2];
                nb[r*3+2] = '0;
            end
        end else begin
            nb = n_win;
        end
        for (int i = 0; i < NB_SIZE; i++) begin
            o_q_pkt.pix[i] = r_s1_keep[i] ? nb[i] : '0;
        end
        o_q_pkt.row  = r_s1_row;
        o_q_pkt.col  = r_s1_col;
        o_q_pkt.last = r_s1_last;
    end

    assign o_q_push = r_s1_v && r_s1_out;

    assign wr_en = r_busy || r_s1_v;
    assign wr_a  = r_busy ? r_clr : r_s1_ic;
    assign wr_d  = r_busy ? '0 : {q[PIX_W-1:0], r_s1_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_clr   <= '0;
            r_ic    <= '0;
            r_ir    <= '0;
            r_s1_v  <= 1'b0;
            r_fwd_v <= 1'b0;
            r_win   <= '0;
        end else begin
            r_s1_v <= acc;
            if (r_busy) begin
                if (r_clr == AW'(MAX_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                end
                r_clr <= r_clr + AW'(1);
            end
            if (acc) begin
                r_ic    <= n_ic;
                r_ir    <= n_ir;
                r_fwd_v <= r_s1_v && (r_s1_ic == ic);
            end
            if (r_s1_v) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fwd_d   <= {q[PIX_W-1:0], r_s1_p};
            r_s1_out  <= valid;
            r_s1_col0 <= (ic == '0);
            r_s1_ic   <= ic;
            r_s1_p    <= p;
            r_s1_keep <= keep;
            r_s1_row  <= ROW_W'(cr);
            r_s1_col  <= ROW_W'(cc);
            r_s1_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_a] <= wr_d;
        end
        if (acc) begin
            r_q <= r_mem[ic];
        end
    end

endmodule

// ----- hw/rtl/cnv3_back.sv -----
// back end: nine multiplies, row sums, final sum; depends on cnv3_pkg;
// one beat per cycle from middle queue to result fifo while it has room
module cnv3_back
    import cnv3_pkg::*;
#(
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [2:0][CFG_DATA_W-1:0] i_kernel,
    input  logic                       i_q_empty,
    input  t_win_pkt                   i_q_pkt,
    input  logic [OCW-1:0]             i_out_count,
    output logic                       o_q_pop,
    output logic                       o_res_push,
    output t_result                    o_res
);

    localparam int PROD_W = COEF_BITS + PIX_W + 1;
    localparam int RSUM_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;

    logic signed [COEF_BITS-1:0] coef [NB_SIZE];
    logic signed [PROD_W-1:0]    prod [NB_SIZE];
    logic signed [PROD_W-1:0]    r_prod [NB_SIZE];
    logic signed [RSUM_W-1:0]    r_rsum [3];
    logic signed [SUM_W-1:0]     total;

    logic             r_va, r_vb;
    logic [ROW_W-1:0] r_row_a, r_row_b;
    logic [ROW_W-1:0] r_col_a, r_col_b;
    logic             r_last_a, r_last_b;

    assign o_q_pop = !i_q_empty
        && ((OCW + 1)'(i_out_count) + (OCW + 1)'(r_va) + (OCW + 1)'(r_vb)
            < (OCW + 1)'(OUT_DEPTH));

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r*3+c] = $signed(i_kernel[r][COEF_SLOT*c +: COEF_BITS]);
            end
        end
        for (int i = 0; i < NB_SIZE; i++) begin
            prod[i] = coef[i] * $signed({1'b0, i_q_pkt.pix[i]});
        end
        total = SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
    end

    assign o_res_push  = r_vb;
    assign o_res.value = VALUE_W'(total);
    assign o_res.row   = r_row_b;
    assign o_res.col   = r_col_b;
    assign o_res.last  = r_last_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= o_q_pop;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_prod   <= prod;
            r_row_a  <= i_q_pkt.row;
            r_col_a  <= i_q_pkt.col;
            r_last_a <= i_q_pkt.last;
        end
        if (r_va) begin
            for (int r = 0; r < 3; r++) begin
                r_rsum[r] <= RSUM_W'(r_prod[r*3]) + RSUM_W'(r_prod[r*3+1])
                    + RSUM_W'(r_prod[r*3+2]);
            end
            r_row_b  <= r_row_a;
            r_col_b  <= r_col_a;
            r_last_b <= r_last_a;
        end
    end

endmodule

// ----- dv/conv3x3_zero_pad_filter_tb.sv -----
// self-checking testbench for the 3x3 zero padded convolution filter
// directed table, widest and tallest frames, then random frames with bursty
// input and stalled output; depends on cnv3_pkg and conv3x3_zero_pad_filter
`timescale 1ns / 1ps

module conv3x3_zero_pad_filter_tb;
    import cnv3_pkg::*;

    localparam int CLK_HALF     = 1;
    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int WIDE_TAIL    = 16;
    localparam int RANDOM_BEATS = 400;
    localparam int TIMEOUT_NS   = 1000000;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_reg    reg_idx;
        logic [47:0] cfg_val;
        logic [7:0]  pix;
        logic        flush;
        logic [7:0]  reps;
        logic        typed;
        t_result     want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic [PIX_W-1:0]          i_pixel = '0;
    logic                      i_flush = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic signed [VALUE_W-1:0] o_filtered_value;
    logic [ROW_W-1:0]          o_out_row;
    logic [ROW_W-1:0]          o_out_col;
    logic                      o_frame_last;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    // filter state mirrored by the predictor
    logic [47:0] kernel_reg [3];
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [7:0]  line_mem [2*MAX_W];
    logic [7:0]  win [9];
    int unsigned in_row;
    int unsigned in_col;

    t_result     result_q [$];
    int          fail_count = 0;
    int unsigned burst_left = 0;
    bit          no_gaps = 1'b0;
    int unsigned beats_sent = 0;

    int          hold_reqs = 0;
    int          holds_taken = 0;
    int          hold_left = 0;
    logic [7:0]  rx_tick = '0;
    int          rx_mode = 0;

    t_stim_row dir_table [24] = '{
        '{1'b1, REG_IMAGE_WIDTH, 48'd1, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b1, REG_IMAGE_HEIGHT, 48'd1, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd7, 1'b0, 8'd1, 1'b0, '0},
        // pixels in the flush rows are masked
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd255, 1'b0, 8'd1, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd170, 1'b0, 8'd1, 1'b1,
          '{28'sd448, 10'd0, 10'd0, 1'b1}},
        // flush inside the frame is a zero pixel
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd200, 1'b1, 8'd1, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd0, 1'b1, 8'd1, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd0, 1'b1, 8'd1, 1'b1,
          '{28'sd0, 10'd0, 10'd0, 1'b1}},
        '{1'b1, REG_KERNEL_TOP, 48'h7FFF_7FFF_7FFF, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b1, REG_KERNEL_MIDDLE, 48'h7FFF_7FFF_7FFF, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b1, REG_KERNEL_BOTTOM, 48'h7FFF_7FFF_7FFF, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd255, 1'b0, 8'd1, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd99, 1'b1, 8'd1, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd99, 1'b1, 8'd1, 1'b1,
          '{28'sd8355585, 10'd0, 10'd0, 1'b1}},
        '{1'b1, REG_KERNEL_TOP, 48'h8000_8000_8000, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b1, REG_KERNEL_MIDDLE, 48'h8000_8000_8000, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b1, REG_KERNEL_BOTTOM, 48'h8000_8000_8000, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd255, 1'b0, 8'd1, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd0, 1'b1, 8'd1, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd0, 1'b1, 8'd1, 1'b1,
          '{-28'sd8355840, 10'd0, 10'd0, 1'b1}},
        '{1'b1, REG_IMAGE_WIDTH, 48'd3, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b1, REG_IMAGE_HEIGHT, 48'd3, 8'd0, 1'b0, 8'd0, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd255, 1'b0, 8'd9, 1'b0, '0},
        '{1'b0, REG_KERNEL_TOP, 48'd0, 8'd0, 1'b1, 8'd4, 1'b0, '0}
    };

    conv3x3_zero_pad_filter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_pixel          (i_pixel),
        .i_flush          (i_flush),
        .empty            (empty),
        .pop              (pop),
        .o_filtered_value (o_filtered_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_frame_last     (o_frame_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int unsigned eff_dim(logic [10:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void predict_pixel(input logic [7:0] pix, input logic flush_bit,
                                          output bit produced, output t_result res);
        int unsigned w, h, row_in, col_in, crow, ccol;
        logic [7:0]  p, up2, up1;
        logic [7:0]  hood [9];
        int          acc, coef;
        bit          ok;
        w = eff_dim(width_reg, MAX_W);
        h = eff_dim(height_reg, MAX_H);
        if (in_col >= w || in_row > h + 1) begin
            in_row = 0;
            in_col = 0;
        end
        row_in = in_row;
        col_in = in_col;
        p = flush_bit ? 8'd0 : pix;
        up2 = line_mem[MAX_W + col_in];
        up1 = line_mem[col_in];
        // first column: centre sits on the last column two rows up
        if (col_in == 0) begin
            for (int r = 0; r < 3; r++) begin
                hood[r*3]     = win[r*3 + 1];
                hood[r*3 + 1] = win[r*3 + 2];
                hood[r*3 + 2] = 8'd0;
            end
        end
        for (int r = 0; r < 3; r++) begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = p;
        if (col_in != 0) hood = win;
        line_mem[MAX_W + col_in] = up1;
        line_mem[col_in] = p;

        crow = 0;
        ccol = 0;
        if (col_in == 0) begin
            ok = (row_in >= 2);
            if (ok) begin
                crow = row_in - 2;
                ccol = w - 1;
            end
        end else begin
            ok = (row_in >= 1);
            if (ok) begin
                crow = row_in - 1;
                ccol = col_in - 1;
            end
        end
        if (ok && crow >= h) ok = 1'b0;

        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
        end
        in_row = row_in;
        in_col = col_in;

        produced = ok;
        res = '0;
        if (!ok) return;

        acc = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && crow == 0) || (r == 2 && crow == h - 1)) continue;
                if ((c == 0 && ccol == 0) || (c == 2 && ccol == w - 1)) continue;
                coef = int'($signed(kernel_reg[r][c*16 +: 16]));
                acc += coef * int'(hood[r*3 + c]);
            end
        end
        res.value = acc[VALUE_W-1:0];
        res.row = crow[ROW_W-1:0];
        res.col = ccol[ROW_W-1:0];
        res.last = (crow == h - 1) && (ccol == w - 1);
        if (res.last) begin
            in_row = 0;
            in_col = 0;
        end
    endfunction

    function automatic logic [7:0] rand_pixel();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'h00;
            1: v = 8'hFF;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic logic [47:0] rand_kernel();
        logic [63:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: t[47:0] = KERNEL_OUTER_RST;
            1: t[47:0] = KERNEL_MIDDLE_RST;
            2: t[47:0] = 48'h7FFF_7FFF_7FFF;
            3: t[47:0] = 48'h8000_8000_8000;
            default: ;
        endcase
        return t[47:0];
    endfunction

    // dimension with junk in the unused upper bits
    function automatic logic [47:0] dim_word(logic [10:0] v);
        logic [63:0] t;
        t = {$urandom, $urandom};
        t[10:0] = v;
        return t[47:0];
    endfunction

    function automatic logic [10:0] pick_dim();
        logic [10:0] v;
        case ($urandom_range(0, 9))
            0: v = 11'd0;
            1: v = 11'd1;
            2: v = 11'd2;
            default: v = 11'($urandom_range(3, 12));
        endcase
        return v;
    endfunction

    task automatic idle_for(int unsigned n);
        @(negedge i_clk);
        push <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [7:0] pix, input logic flush_bit,
                              input bit typed, input t_result typed_res);
        bit      produced;
        t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!no_gaps) idle_for($urandom_range(1, 8));
        end
        burst_left--;
        @(negedge i_clk);
        push <= 1'b1;
        i_pixel <= pix;
        i_flush <= flush_bit;
        do @(posedge i_clk); while (full);
        beats_sent++;
        predict_pixel(pix, flush_bit, produced, res);
        if (typed) begin
            produced = 1'b1;
            res = typed_res;
        end
        if (produced) result_q.push_back(res);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [47:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_KERNEL_TOP:    kernel_reg[0] = data;
            REG_KERNEL_MIDDLE: kernel_reg[1] = data;
            REG_KERNEL_BOTTOM: kernel_reg[2] = data;
            REG_IMAGE_WIDTH:   width_reg = data[10:0];
            REG_IMAGE_HEIGHT:  height_reg = data[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // style: 0 clean, 1 flush noise in frame, 2 pixels in flush rows,
    // 3 cut short, 4 extra trailing beats
    task automatic send_frame(int unsigned style);
        int unsigned w, h, n_pix, n_total, cut;
        logic        fl;
        w = eff_dim(width_reg, MAX_W);
        h = eff_dim(height_reg, MAX_H);
        n_pix = w * h;
        n_total = n_pix + w + 1;
        if (style == 4) n_total += $urandom_range(1, w + 2);
        cut = (style == 3) ? $urandom_range(1, n_total - 1) : n_total;
        for (int unsigned k = 0; k < cut; k++) begin
            if (k < n_pix) fl = (style == 1) && ($urandom_range(0, 3) == 0);
            else fl = (style == 2) ? 1'($urandom_range(0, 1)) : 1'b1;
            send_pixel(rand_pixel(), fl, 1'b0, '0);
        end
    endtask

    task automatic write_kernels();
        cfg_write(REG_KERNEL_TOP, rand_kernel());
        cfg_write(REG_KERNEL_MIDDLE, rand_kernel());
        cfg_write(REG_KERNEL_BOTTOM, rand_kernel());
    endtask

    // output side: stall pattern of its own plus long hold-offs on request
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick[5:0] == 6'd0) rx_mode <= $urandom_range(0, 3);
        if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_taken != hold_reqs) begin
            holds_taken <= holds_taken + 1;
            hold_left <= HOLD_CYCLES - 1;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= (rx_tick[1:0] == 2'd0);
                default: pop <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (result_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat value %0d row %0d col %0d last %0b", $time,
                         o_filtered_value, o_out_row, o_out_col, o_frame_last);
            end else begin
                want = result_q.pop_front();
                if (o_filtered_value !== want.value || o_out_row !== want.row ||
                    o_out_col !== want.col || o_frame_last !== want.last) begin
                    fail_count++;
                    $display("%0t: expected value %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                             $time, want.value, want.row, want.col, want.last,
                             o_filtered_value, o_out_row, o_out_col, o_frame_last);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned start_beats;
        int unsigned n_frames;
        t_result     typed_res;
        kernel_reg[0] = KERNEL_OUTER_RST;
        kernel_reg[1] = KERNEL_MIDDLE_RST;
        kernel_reg[2] = KERNEL_OUTER_RST;
        width_reg = DIM_RST;
        height_reg = DIM_RST;
        foreach (line_mem[i]) line_mem[i] = 8'd0;
        foreach (win[i]) win[i] = 8'd0;
        in_row = 0;
        in_col = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg) begin
                wait_idle();
                cfg_write(dir_table[i].reg_idx, dir_table[i].cfg_val);
            end else begin
                typed_res = dir_table[i].want;
                repeat (dir_table[i].reps)
                    send_pixel(dir_table[i].pix, dir_table[i].flush, dir_table[i].typed,
                               typed_res);
            end
        end

        // widest frame, clamped from above the maximum, cut short in the flush row
        wait_idle();
        write_kernels();
        cfg_write(REG_IMAGE_WIDTH, dim_word(11'd2047));
        cfg_write(REG_IMAGE_HEIGHT, dim_word(11'd0));
        repeat (MAX_W) send_pixel(rand_pixel(), 1'b0, 1'b0, '0);
        repeat (WIDE_TAIL) send_pixel(rand_pixel(), 1'b1, 1'b0, '0);

        // tallest frame with the output held off
        wait_idle();
        write_kernels();
        cfg_write(REG_IMAGE_WIDTH, dim_word(11'd1));
        cfg_write(REG_IMAGE_HEIGHT, dim_word(11'd2047));
        hold_reqs <= hold_reqs + 1;
        send_frame(0);

        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            wait_idle();
            if ($urandom_range(0, 5) == 0) hold_reqs <= hold_reqs + 1;
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) cfg_write(REG_KERNEL_TOP, rand_kernel());
            if ($urandom_range(0, 1)) cfg_write(REG_KERNEL_MIDDLE, rand_kernel());
            if ($urandom_range(0, 1)) cfg_write(REG_KERNEL_BOTTOM, rand_kernel());
            if ($urandom_range(0, 2) != 0) cfg_write(REG_IMAGE_WIDTH, dim_word(pick_dim()));
            if ($urandom_range(0, 2) != 0) cfg_write(REG_IMAGE_HEIGHT, dim_word(pick_dim()));
            n_frames = $urandom_range(1, 3);
            repeat (n_frames)
                send_frame(($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 4));
        end

        wait_idle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
